FILE: design/wide_string_to_integer_parser_macros.svh
// assertion macros for the wide string to integer parser datapath
`ifndef WIDE_STRING_TO_INTEGER_PARSER_MACROS_SVH
`define WIDE_STRING_TO_INTEGER_PARSER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define WSTOI_ASSERT_NOW(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wstoi same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define WSTOI_ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wstoi next-cycle check failed");

`endif

FILE: design/wstoi_pkg.sv
// shared types, constants and digit decoding for the string to integer parser
`timescale 1ns / 1ps

package wstoi_pkg;

	// character position counter width
	localparam int POS_BITS = 16;

	// register indexes on the configuration port
	localparam logic REG_RADIX       = 1'b0;
	localparam logic REG_SIGNED_MODE = 1'b1;

	localparam logic [5:0] RADIX_RESET = 6'd10;
	localparam logic [5:0] RADIX_MAX   = 6'd36;

	// character codes
	localparam logic [15:0] CH_NUL   = 16'h0000;
	localparam logic [15:0] CH_TAB   = 16'h0009;
	localparam logic [15:0] CH_CR    = 16'h000D;
	localparam logic [15:0] CH_SPACE = 16'h0020;
	localparam logic [15:0] CH_NBSP  = 16'h00A0;
	localparam logic [15:0] CH_PLUS  = 16'h002B;
	localparam logic [15:0] CH_MINUS = 16'h002D;
	localparam logic [15:0] CH_UPX   = 16'h0058;
	localparam logic [15:0] CH_LOWX  = 16'h0078;
	localparam logic [15:0] CH_D0    = 16'h0030;
	localparam logic [15:0] CH_D9    = 16'h0039;
	localparam logic [15:0] CH_UPA   = 16'h0041;
	localparam logic [15:0] CH_UPZ   = 16'h005A;
	localparam logic [15:0] CH_LOWA  = 16'h0061;
	localparam logic [15:0] CH_LOWZ  = 16'h007A;

	// zero code points of the unicode decimal digit blocks
	localparam int NUM_BLOCKS = 17;
	localparam logic [15:0] DIGIT_ZERO_POINTS [NUM_BLOCKS] = '{
		16'h0660, 16'h06F0, 16'h0966, 16'h09E6, 16'h0A66, 16'h0AE6,
		16'h0B66, 16'h0C66, 16'h0CE6, 16'h0D66, 16'h0E50, 16'h0ED0,
		16'h0F20, 16'h1040, 16'h17E0, 16'h1810, 16'hFF10
	};

	// how the base register is loaded on a beat
	typedef enum logic [2:0] {
		BOP_KEEP,
		BOP_RADIX,
		BOP_FIRST_R,
		BOP_FIRST_B,
		BOP_OCTAL,
		BOP_HEX
	} base_op_t;

	// commands from the controller to the datapath
	typedef struct packed {
		base_op_t base_op;
		logic     set_sign;
		logic     pos_inc;
		logic     mark_zero;
		logic     take_digit;
		logic     emit;
	} dp_cmd_t;

	// classification of the current character
	typedef struct packed {
		logic is_nul;
		logic is_space;
		logic is_sign;
		logic is_x;
		logic radix_bad;
		logic zp_radix;
		logic zp_base;
		logic ok_first_r;
		logic ok_first_b;
		logic ok_octal;
		logic ok_keep;
	} dp_status_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} digit_t;

	// digit value of a code unit in any base up to 36
	function automatic digit_t digit_of(input logic [15:0] c);
		digit_t     d;
		logic [15:0] off;
		d.valid = 1'b0;
		d.value = '0;
		if (c >= CH_D0 && c <= CH_D9) begin
			d.valid = 1'b1;
			d.value = 6'(c - CH_D0);
		end else if (c >= CH_UPA && c <= CH_UPZ) begin
			d.valid = 1'b1;
			d.value = 6'(c - CH_UPA + 16'd10);
		end else if (c >= CH_LOWA && c <= CH_LOWZ) begin
			d.valid = 1'b1;
			d.value = 6'(c - CH_LOWA + 16'd10);
		end else begin
			for (int i = 0; i < NUM_BLOCKS; i++) begin
				off = c - DIGIT_ZERO_POINTS[i];
				if (c >= DIGIT_ZERO_POINTS[i] && off < 16'd10) begin
					d.valid = 1'b1;
					d.value = 6'(off);
				end
			end
		end
		return d;
	endfunction

endpackage

FILE: design/wstoi_ctrl.sv
// parse phase controller for the string to integer parser
`timescale 1ns / 1ps

module wstoi_ctrl
	import wstoi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       beat,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_FIRST,
		PH_ZERO,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	phase_t phase_q;
	phase_t phase_d;

	// command decode for the character on the input beat
	always_comb begin
		cmd         = '0;
		cmd.base_op = BOP_KEEP;
		phase_d     = phase_q;
		if (beat) begin
			if (status.is_nul) begin
				cmd.emit      = 1'b1;
				cmd.mark_zero = (phase_q == PH_ZERO);
				phase_d       = PH_SKIP;
			end else begin
				unique case (phase_q)
					PH_SKIP: begin
						if (status.is_space) begin
							cmd.pos_inc = 1'b1;
						end else if (status.radix_bad) begin
							phase_d = PH_DONE;
						end else if (status.is_sign) begin
							cmd.base_op  = BOP_RADIX;
							cmd.set_sign = 1'b1;
							cmd.pos_inc  = 1'b1;
							phase_d      = PH_FIRST;
						end else if (status.zp_radix) begin
							cmd.base_op = BOP_RADIX;
							cmd.pos_inc = 1'b1;
							phase_d     = PH_ZERO;
						end else begin
							cmd.base_op    = BOP_FIRST_R;
							cmd.take_digit = status.ok_first_r;
							phase_d        = status.ok_first_r ? PH_DIGITS : PH_DONE;
						end
					end
					PH_FIRST: begin
						if (status.zp_base) begin
							cmd.pos_inc = 1'b1;
							phase_d     = PH_ZERO;
						end else begin
							cmd.base_op    = BOP_FIRST_B;
							cmd.take_digit = status.ok_first_b;
							phase_d        = status.ok_first_b ? PH_DIGITS : PH_DONE;
						end
					end
					PH_ZERO: begin
						if (status.is_x) begin
							cmd.base_op = BOP_HEX;
							cmd.pos_inc = 1'b1;
							phase_d     = PH_DIGITS;
						end else begin
							cmd.base_op    = BOP_OCTAL;
							cmd.mark_zero  = 1'b1;
							cmd.take_digit = status.ok_octal;
							phase_d        = status.ok_octal ? PH_DIGITS : PH_DONE;
						end
					end
					PH_DIGITS: begin
						cmd.take_digit = status.ok_keep;
						if (!status.ok_keep) begin
							phase_d = PH_DONE;
						end
					end
					PH_DONE: begin
						phase_d = PH_DONE;
					end
					default: begin
						phase_d = PH_SKIP;
					end
				endcase
			end
		end
	end

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
		end else begin
			phase_q <= phase_d;
		end
	end

endmodule

FILE: design/wstoi_dp.sv
// datapath of the string to integer parser: classifier, accumulator, result register
`timescale 1ns / 1ps

`include "wide_string_to_integer_parser_macros.svh"

module wstoi_dp
	import wstoi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data,
	input  logic [15:0] char_code,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	output logic        in_free,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata
);

	logic [5:0]          radix_q;
	logic                signed_q;
	logic                neg_q;
	logic [31:0]         acc_q;
	logic [5:0]          base_q;
	logic [POS_BITS-1:0] pos_q;
	logic [POS_BITS-1:0] last_q;
	logic                any_q;
	logic                out_valid_q;
	logic [55:0]         out_data_q;

	digit_t              dig;
	logic [5:0]          base_first_r;
	logic [5:0]          base_first_b;
	logic [5:0]          base_octal;
	logic [5:0]          base_use;
	logic [37:0]         prod;
	logic [38:0]         sum;
	logic [38:0]         limit;
	logic [31:0]         acc_next;
	logic [POS_BITS-1:0] pos_next;
	logic                any_f;
	logic [POS_BITS-1:0] last_f;
	logic [31:0]         value_f;

	// character classification and base candidates
	always_comb begin
		dig          = digit_of(char_code);
		base_first_r = (radix_q == 6'd0) ? 6'd10 : radix_q;
		base_first_b = (base_q == 6'd0) ? 6'd10 : base_q;
		base_octal   = (base_q == 6'd0) ? 6'd8 : base_q;

		status.is_nul     = (char_code == CH_NUL);
		status.is_space   = (char_code >= CH_TAB && char_code <= CH_CR) ||
			(char_code == CH_SPACE) || (char_code == CH_NBSP);
		status.is_sign    = (char_code == CH_PLUS) || (char_code == CH_MINUS);
		status.is_x       = (char_code == CH_LOWX) || (char_code == CH_UPX);
		status.radix_bad  = (radix_q == 6'd1) || (radix_q > RADIX_MAX);
		status.zp_radix   = ((radix_q == 6'd0) || (radix_q == 6'd16)) &&
			dig.valid && (dig.value == 6'd0);
		status.zp_base    = ((base_q == 6'd0) || (base_q == 6'd16)) &&
			dig.valid && (dig.value == 6'd0);
		status.ok_first_r = dig.valid && (dig.value < base_first_r);
		status.ok_first_b = dig.valid && (dig.value < base_first_b);
		status.ok_octal   = dig.valid && (dig.value < base_octal);
		status.ok_keep    = dig.valid && (dig.value < base_q);
	end

	// base selection and saturating multiply-add
	always_comb begin
		case (cmd.base_op)
			BOP_RADIX:   base_use = radix_q;
			BOP_FIRST_R: base_use = base_first_r;
			BOP_FIRST_B: base_use = base_first_b;
			BOP_OCTAL:   base_use = base_octal;
			BOP_HEX:     base_use = 6'd16;
			default:     base_use = base_q;
		endcase
		prod = acc_q * base_use;
		sum  = {1'b0, prod} + {33'd0, dig.value};
		if (signed_q) begin
			limit = neg_q ? 39'h0080000000 : 39'h007FFFFFFF;
		end else begin
			limit = 39'h00FFFFFFFF;
		end
		acc_next = (sum > limit) ? limit[31:0] : sum[31:0];
		pos_next = pos_q + POS_BITS'(cmd.pos_inc || cmd.take_digit);
	end

	// result of the string at the terminator
	always_comb begin
		any_f   = any_q || cmd.mark_zero;
		last_f  = cmd.mark_zero ? pos_q : last_q;
		value_f = any_f ? (neg_q ? (32'd0 - acc_q) : acc_q) : 32'd0;
	end

	assign in_free  = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= RADIX_RESET;
			signed_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIX:       radix_q  <= cfg_data;
				REG_SIGNED_MODE: signed_q <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	// parse state, cleared after each terminator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q  <= 1'b0;
			acc_q  <= '0;
			base_q <= '0;
			pos_q  <= '0;
			last_q <= '0;
			any_q  <= 1'b0;
		end else if (cmd.emit) begin
			neg_q  <= 1'b0;
			acc_q  <= '0;
			base_q <= '0;
			pos_q  <= '0;
			last_q <= '0;
			any_q  <= 1'b0;
		end else begin
			base_q <= base_use;
			pos_q  <= pos_next;
			if (cmd.set_sign) begin
				neg_q <= (char_code == CH_MINUS);
			end
			if (cmd.mark_zero) begin
				any_q  <= 1'b1;
				last_q <= pos_q;
			end
			if (cmd.take_digit) begin
				any_q  <= 1'b1;
				last_q <= pos_next;
				acc_q  <= acc_next;
			end
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= {7'd0, any_f, 16'(last_f), value_f};
		end
	end

	// result is loaded only into a free or draining output register
	`WSTOI_ASSERT_NOW(a_emit_free, clk, arst_n, cmd.emit, !out_valid_q || m_tready)
	// a loaded result is offered in the following cycle
	`WSTOI_ASSERT_NEXT(a_emit_shown, clk, arst_n, cmd.emit, out_valid_q)
	// an accepted digit marks the string as converted
	`WSTOI_ASSERT_NEXT(a_digit_seen, clk, arst_n, cmd.take_digit, any_q && (last_q == pos_q))

endmodule

FILE: design/wide_string_to_integer_parser.sv
// Wide string to integer parser: one UTF-16 code unit per input beat.
// Input channel s_*: each beat carries one code unit in s_tdata; code 0 ends
// the string. Whitespace is skipped, an optional sign and a 0x prefix are
// taken, then digits are accumulated with saturation until a non-digit.
// Output channel m_*: one beat per terminator with the value, the count of
// code units through the last digit and a converted flag.
// Configuration: cfg_we with cfg_index 0 writes the radix (0 auto, 2..36),
// index 1 writes signed mode; write only while the block is idle.
// Throughput is one code unit per cycle while the output is not stalled: each
// beat is handled by a 32 by 6 multiply-add into the accumulator register.
// The result beat is registered and appears the cycle after the terminator beat.
// A stalled output holds the result; s_tready stays high while the output
// register is empty or being taken, and drops for every input beat while a
// held result waits with m_tready low.
// Reset clears the parse state and sets radix 10, signed mode on.
`timescale 1ns / 1ps

module wide_string_to_integer_parser
	import wstoi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // char_code[15:0]
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // value_bits[31:0], end_offset[47:32], converted[48]
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       in_free;
	logic       beat;

	assign s_tready = in_free;
	assign beat     = s_tvalid && in_free;

	// phase controller
	wstoi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.beat   (beat),
		.status (status),
		.cmd    (cmd)
	);

	// datapath and result register
	wstoi_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.char_code (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.in_free   (in_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

FILE: bench/tb.sv
// self-checking bench for the wide string to integer parser
`timescale 1ns / 1ps

module tb;
	import wstoi_pkg::*;

	// zero code points of the unicode decimal blocks, kept apart from the rtl copy
	localparam logic [15:0] UNI_ZEROS [17] = '{
		16'h0660, 16'h06F0, 16'h0966, 16'h09E6, 16'h0A66, 16'h0AE6,
		16'h0B66, 16'h0C66, 16'h0CE6, 16'h0D66, 16'h0E50, 16'h0ED0,
		16'h0F20, 16'h1040, 16'h17E0, 16'h1810, 16'hFF10
	};

	typedef enum logic [2:0] {
		PS_SKIP,
		PS_SIGNED,
		PS_ZERO,
		PS_DIGITS,
		PS_DONE
	} parse_phase_t;

	typedef struct packed {
		logic        converted;
		logic [15:0] end_offset;
		logic [31:0] value;
	} parse_result_t;

	// running parse of the character stream and the results it owes
	class parse_scoreboard;
		logic [5:0]    radix;
		logic          signed_mode;
		parse_phase_t  phase;
		logic          negative;
		logic [31:0]   magnitude;
		logic [5:0]    base;
		logic [15:0]   position;
		logic [15:0]   last_digit_pos;
		logic          zero_held;
		logic          seen_digit;
		parse_result_t owed_q[$];
		int            errors;
		int            strings;
		int            converted;
		int            clipped;

		function new();
			radix       = RADIX_RESET;
			signed_mode = 1'b1;
			errors      = 0;
			strings     = 0;
			converted   = 0;
			clipped     = 0;
			clear();
		endfunction

		function void set_reg(input logic idx, input logic [5:0] val);
			if (idx == REG_RADIX) radix = val;
			else signed_mode = val[0];
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function void clear();
			phase          = PS_SKIP;
			negative       = 1'b0;
			magnitude      = '0;
			base           = '0;
			position       = '0;
			last_digit_pos = '0;
			zero_held      = 1'b0;
			seen_digit     = 1'b0;
		endfunction

		function bit is_blank(input logic [15:0] c);
			return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE || c == CH_NBSP;
		endfunction

		// digit value in any base up to 36, -1 for a non-digit
		function int digit_value(input logic [15:0] c);
			int v;
			v = -1;
			if (c >= CH_D0 && c <= CH_D9) v = int'(c - CH_D0);
			else if (c >= CH_UPA && c <= CH_UPZ) v = int'(c - CH_UPA) + 10;
			else if (c >= CH_LOWA && c <= CH_LOWZ) v = int'(c - CH_LOWA) + 10;
			else begin
				foreach (UNI_ZEROS[i])
					if (c >= UNI_ZEROS[i] && c <= UNI_ZEROS[i] + 9) v = int'(c - UNI_ZEROS[i]);
			end
			return v;
		endfunction

		// multiply-add with saturation at the mode's limit
		function void accumulate(input int v);
			logic [63:0] t;
			logic [31:0] limit;
			if (signed_mode) limit = negative ? 32'h8000_0000 : 32'h7FFF_FFFF;
			else limit = 32'hFFFF_FFFF;
			t = 64'(magnitude) * 64'(base) + 64'(v);
			if (t > 64'(limit)) begin
				magnitude = limit;
				clipped++;
			end else begin
				magnitude = t[31:0];
			end
		endfunction

		function void digit_step(input logic [15:0] c);
			int v;
			v = digit_value(c);
			if (v < 0 || v >= int'(base)) begin
				phase = PS_DONE;
				return;
			end
			position++;
			seen_digit     = 1'b1;
			last_digit_pos = position;
			accumulate(v);
		endfunction

		function void take_zero();
			if (base == 0) base = 6'd8;
			zero_held      = 1'b0;
			seen_digit     = 1'b1;
			last_digit_pos = position;
			accumulate(0);
		endfunction

		function void first_digit(input logic [15:0] c);
			int v;
			v = digit_value(c);
			if ((base == 0 || base == 16) && v == 0) begin
				zero_held = 1'b1;
				position++;
				phase = PS_ZERO;
				return;
			end
			if (base == 0) base = (v != 0) ? 6'd10 : 6'd8;
			phase = PS_DIGITS;
			digit_step(c);
		endfunction

		// accepted input beat
		function void note_char(input logic [15:0] c);
			parse_result_t r;
			if (c == CH_NUL) begin
				if (phase == PS_ZERO && zero_held) take_zero();
				r.value      = !seen_digit ? 32'd0 : negative ? 32'd0 - magnitude : magnitude;
				r.end_offset = seen_digit ? last_digit_pos : 16'd0;
				r.converted  = seen_digit;
				owed_q.push_back(r);
				strings++;
				if (seen_digit) converted++;
				clear();
				return;
			end
			case (phase)
				PS_SKIP: begin
					if (is_blank(c)) begin
						position++;
					end else if (radix == 1 || radix > RADIX_MAX) begin
						phase = PS_DONE;
					end else begin
						base = radix;
						if (c == CH_MINUS || c == CH_PLUS) begin
							negative = (c == CH_MINUS);
							position++;
							phase = PS_SIGNED;
						end else begin
							first_digit(c);
						end
					end
				end
				PS_SIGNED: first_digit(c);
				PS_ZERO: begin
					if (c == CH_LOWX || c == CH_UPX) begin
						base      = 6'd16;
						zero_held = 1'b0;
						position++;
						phase = PS_DIGITS;
					end else begin
						take_zero();
						phase = PS_DIGITS;
						digit_step(c);
					end
				end
				PS_DIGITS: digit_step(c);
				default: ;
			endcase
		endfunction

		// accepted result beat against the oldest owed result
		function void check_result(input logic [55:0] d);
			parse_result_t want;
			if (owed_q.size() == 0) begin
				errors++;
				$display("%0t: result beat with none owed, expected nothing, got %h", $time, d);
				return;
			end
			want = owed_q.pop_front();
			if (d[31:0] !== want.value) begin
				errors++;
				$display("%0t: value_bits expected %h, got %h", $time, want.value, d[31:0]);
			end
			if (d[47:32] !== want.end_offset) begin
				errors++;
				$display("%0t: end_offset expected %0d, got %0d", $time, want.end_offset,
					d[47:32]);
			end
			if (d[48] !== want.converted) begin
				errors++;
				$display("%0t: converted expected %b, got %b", $time, want.converted, d[48]);
			end
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = 1'b0;
	logic [5:0]  cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [55:0] m_tdata;

	parse_scoreboard sb;
	int              burst_left = 0;
	bit              hold_req   = 1'b0;
	int              settings   = 0;

	wide_string_to_integer_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// beat monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			if (s_tvalid && s_tready) sb.note_char(s_tdata);
		end
	end

	// receiver: stall density redrawn from four levels at the end of each span, long hold on request
	initial begin
		int pct;
		int span;
		pct  = 100;
		span = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			if (span == 0) begin
				case ($urandom_range(0, 3))
					0: pct = 100;
					1: pct = 75;
					2: pct = 40;
					default: pct = 10;
				endcase
				span = 50;
			end
			span--;
			m_tready <= ($urandom_range(1, 100) <= pct);
		end
	end

	// one character beat, with bursts and random gaps on the sender side
	task automatic send_char(input logic [15:0] c);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_string(ref logic [15:0] s[$]);
		foreach (s[i]) send_char(s[i]);
	endtask

	// stop sending and let every owed result come out
	task automatic wait_idle(input int settle);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [5:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic set_mode(input logic [5:0] rdx, input logic sgn);
		wait_idle(4);
		write_reg(REG_RADIX, rdx);
		write_reg(REG_SIGNED_MODE, {5'd0, sgn});
		settings++;
	endtask

	function automatic logic [15:0] blank_char();
		int r;
		r = $urandom_range(0, 6);
		if (r < 5) return CH_TAB + 16'(r);
		return (r == 5) ? CH_SPACE : CH_NBSP;
	endfunction

	function automatic logic [15:0] digit_char(input int v);
		if (v >= 10) return ($urandom_range(0, 1) ? CH_UPA : CH_LOWA) + 16'(v - 10);
		if ($urandom_range(0, 3) == 0) return UNI_ZEROS[$urandom_range(0, 16)] + 16'(v);
		return CH_D0 + 16'(v);
	endfunction

	// mostly well-formed numbers with random content, some plain noise
	function automatic void build_string(ref logic [15:0] s[$], input logic [5:0] rdx);
		int b;
		int n;
		s.delete();
		if ($urandom_range(0, 9) < 2) begin
			n = $urandom_range(0, 6);
			repeat (n) s.push_back(16'($urandom_range(1, 65535)));
		end else begin
			repeat ($urandom_range(0, 2)) s.push_back(blank_char());
			case ($urandom_range(0, 3))
				0: s.push_back(CH_MINUS);
				1: s.push_back(CH_PLUS);
				default: ;
			endcase
			b = (rdx >= 2 && rdx <= RADIX_MAX) ? int'(rdx) : 10;
			if ((rdx == 0 || rdx == 16) && $urandom_range(0, 2) == 0) begin
				s.push_back(CH_D0);
				s.push_back($urandom_range(0, 1) ? CH_LOWX : CH_UPX);
				b = 16;
			end else if (rdx == 0 && $urandom_range(0, 3) == 0) begin
				s.push_back(CH_D0);
				b = 8;
			end
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 34) : $urandom_range(0, 8);
			repeat (n) s.push_back(digit_char($urandom_range(0, b - 1)));
			if ($urandom_range(0, 2) == 0) s.push_back(16'($urandom_range(1, 65535)));
		end
		s.push_back(CH_NUL);
	endfunction

	// overall time limit
	initial begin
		#50_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// main sequence
	initial begin
		logic [15:0] str[$];
		logic [5:0]  radix_list[12];
		int          phase_chars;
		sb = new();
		radix_list = '{6'd0, 6'd2, 6'd16, 6'd36, 6'd1, 6'd8, 6'd63, 6'd10,
			6'd0, 6'd37, 6'd16, 6'd36};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: decimal, signed; whitespace, sign, 0xffff as a stopper
		str = '{CH_TAB, CH_MINUS, CH_D0 + 16'd1, CH_D0 + 16'd2, CH_NUL};
		send_string(str);
		str = '{CH_NBSP, 16'hFFFF, CH_NUL};
		send_string(str);

		// auto base: hex prefix, prefix with no digits, lone zero, octal stop
		set_mode(6'd0, 1'b1);
		str = '{CH_D0, CH_LOWX, CH_D0 + 16'd1, CH_UPA + 16'd5, CH_NUL};
		send_string(str);
		str = '{CH_D0, CH_UPX, CH_NUL};
		send_string(str);
		str = '{CH_D0, CH_NUL};
		send_string(str);
		str = '{CH_D0, CH_D0 + 16'd7, CH_D0 + 16'd9, CH_NUL};
		send_string(str);

		// base 36 unsigned: modular negate, unicode digits
		set_mode(6'd36, 1'b0);
		str = '{CH_MINUS, CH_LOWZ, CH_NUL};
		send_string(str);
		str = '{16'hFF19, 16'h0669, CH_NUL};
		send_string(str);

		// base one is invalid
		set_mode(6'd1, 1'b1);
		str = '{CH_D0 + 16'd5, CH_NUL};
		send_string(str);

		// random strings across register settings
		foreach (radix_list[p]) begin
			set_mode(radix_list[p], (p % 3) != 0);
			if (p == 4) hold_req = 1'b1;
			phase_chars = 0;
			while (phase_chars < 115) begin
				build_string(str, radix_list[p]);
				send_string(str);
				phase_chars += str.size();
			end
		end

		wait_idle(10);
		$display("parsed %0d strings over %0d register settings, %0d converted",
			sb.strings, settings + 1, sb.converted);
		$display("%0d digits hit the saturation limit", sb.clipped);
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: wide_string_to_integer_parser.f
+incdir+design
design/wstoi_pkg.sv
design/wstoi_ctrl.sv
design/wstoi_dp.sv
design/wide_string_to_integer_parser.sv
bench/tb.sv
